// ----- src/aps_pkg.sv -----
// Shared types, codes and defaults for the aging priority scheduler.
package aps_pkg;

    localparam int MAX_TASKS_DEF = 16;

    localparam logic [2:0] OP_APPEND  = 3'd0;
    localparam logic [2:0] OP_REMOVE  = 3'd1;
    localparam logic [2:0] OP_SETPRIO = 3'd2;
    localparam logic [2:0] OP_SCHED   = 3'd3;
    localparam logic [2:0] OP_QUERY   = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    localparam logic [1:0] CFG_AGING_STEP   = 2'd0;
    localparam logic [1:0] CFG_PRIO_FLOOR   = 2'd1;
    localparam logic [1:0] CFG_PRIO_CEILING = 2'd2;

    localparam logic signed [5:0] AGING_STEP_RST   = -6'sd1;
    localparam logic signed [7:0] PRIO_FLOOR_RST   = -8'sd128;
    localparam logic signed [7:0] PRIO_CEILING_RST = 8'sd127;

    typedef struct packed {
        logic [2:0]        opcode;
        logic [7:0]        task_id;
        logic signed [7:0] static_prio;
        logic signed [7:0] dynamic_prio;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [7:0]        out_task_id;
        logic signed [7:0] out_static_prio;
        logic signed [7:0] out_dynamic_prio;
    } t_out_item;

    typedef struct packed {
        logic [7:0]        task_id;
        logic signed [7:0] static_prio;
        logic signed [7:0] dynamic_prio;
    } t_entry;

    typedef struct packed {
        logic              match;
        logic              less;
        logic signed [7:0] aged;
    } t_alu_res;

endpackage

// ----- src/aps_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module aps_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/aps_alu.sv -----
// Shared compare / aging unit applied to one table entry per cycle.
module aps_alu import aps_pkg::*; (
    input  t_entry            i_entry,
    input  logic [7:0]        i_task_id,
    input  logic signed [7:0] i_best_dyn,
    input  logic signed [5:0] i_step,
    input  logic signed [7:0] i_floor,
    input  logic signed [7:0] i_ceiling,
    output t_alu_res          o_res
);

    logic signed [8:0] sum;
    logic signed [8:0] lo;
    logic signed [8:0] hi;

    always_comb begin
        sum = 9'(i_entry.dynamic_prio) + 9'(i_step);
        lo  = 9'(i_floor);
        hi  = 9'(i_ceiling);
        o_res.match = (i_entry.task_id == i_task_id);
        o_res.less  = (i_entry.dynamic_prio < i_best_dyn);
        // floor first; inverted: floor if below it, else ceiling
        if (sum < lo) begin
            o_res.aged = i_floor;
        end else if (sum > hi) begin
            o_res.aged = i_ceiling;
        end else begin
            o_res.aged = sum[7:0];
        end
    end

endmodule

// ----- src/aging_priority_scheduler.sv -----
// Append, spare opcodes, FULL and EMPTY go via the result register to the output register;
// remove/set/query search the table and remove then compacts it; schedule scans, then ages.
// Throughput: one item at a time; the table RAM gives one entry per cycle to
// a shared compare/aging unit, so each scan reads every ready task in turn.
// Reset (synchronous, active low): table empty, config registers at defaults, no
// result pending; no clearing pass is needed.
module aging_priority_scheduler import aps_pkg::*; #(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item,
    input  logic      i_cfg_we,
    input  logic [1:0] i_cfg_addr,
    input  logic [7:0] i_cfg_wdata
);

    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FIND  = 6'b000010,
        S_SHIFT = 6'b000100,
        S_SCAN  = 6'b001000,
        S_AGE   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx, n_idx;
    logic [IW-1:0]     r_pidx, n_pidx;
    logic              r_pvld, n_pvld;
    logic [IW-1:0]     r_best_idx, n_best_idx;
    t_entry            r_best, n_best;
    t_in_item          r_req, n_req;
    t_out_item         r_res, n_res;
    t_out_item         r_out, n_out;
    logic              r_out_vld, n_out_vld;
    logic signed [5:0] r_step;
    logic signed [7:0] r_floor;
    logic signed [7:0] r_ceiling;

    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    t_entry            ram_wdata;
    t_entry            rd_entry;
    t_alu_res          alu;
    logic              last;

    aps_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_TASKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (rd_entry)
    );

    aps_alu u_alu (
        .i_entry    (rd_entry),
        .i_task_id  (r_req.task_id),
        .i_best_dyn (r_best.dynamic_prio),
        .i_step     (r_step),
        .i_floor    (r_floor),
        .i_ceiling  (r_ceiling),
        .o_res      (alu)
    );

    assign last        = (CW'(r_pidx) == r_count - CW'(1));
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_pidx     = r_pidx;
        n_pvld     = 1'b0;
        n_best_idx = r_best_idx;
        n_best     = r_best;
        n_req      = r_req;
        n_res      = r_res;
        n_out      = r_out;
        n_out_vld  = r_out_vld;
        ram_we     = 1'b0;
        ram_waddr  = r_pidx;
        ram_wdata  = rd_entry;

        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end

        // read-ahead: one entry issued per cycle while scanning
        if (r_state == S_FIND || r_state == S_SHIFT || r_state == S_SCAN ||
            r_state == S_AGE) begin
            n_pidx = r_idx[IW-1:0];
            if (r_idx < r_count) begin
                n_pvld = 1'b1;
                n_idx  = r_idx + CW'(1);
            end
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_item;
                    n_idx   = '0;
                    n_res   = '0;
                    n_state = S_DONE;
                    case (i_in_item.opcode)
                        OP_APPEND: begin
                            if (r_count == CW'(MAX_TASKS)) begin
                                n_res.status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_count[IW-1:0];
                                ram_wdata = '{i_in_item.task_id, i_in_item.static_prio,
                                              i_in_item.dynamic_prio};
                                n_count   = r_count + CW'(1);
                                n_res     = '{ST_OK, i_in_item.task_id,
                                              i_in_item.static_prio,
                                              i_in_item.dynamic_prio};
                            end
                        end
                        OP_REMOVE, OP_SETPRIO, OP_QUERY: begin
                            if (r_count == '0) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                n_state = S_FIND;
                            end
                        end
                        OP_SCHED: begin
                            if (r_count == '0) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_res.status = ST_OK;
                        end
                    endcase
                end
            end
            S_FIND: begin
                if (r_pvld) begin
                    if (alu.match) begin
                        n_res   = '{ST_OK, rd_entry.task_id, rd_entry.static_prio,
                                    rd_entry.dynamic_prio};
                        n_state = S_DONE;
                        if (r_req.opcode == OP_SETPRIO) begin
                            ram_we    = 1'b1;
                            ram_wdata = '{rd_entry.task_id, r_req.static_prio,
                                          r_req.static_prio};
                            n_res.out_static_prio  = r_req.static_prio;
                            n_res.out_dynamic_prio = r_req.static_prio;
                        end else if (r_req.opcode == OP_REMOVE) begin
                            if (last) begin
                                n_count = r_count - CW'(1);
                            end else begin
                                // close the gap: copy each later entry down one slot
                                n_idx   = CW'(r_pidx) + CW'(1);
                                n_pvld  = 1'b0;
                                n_state = S_SHIFT;
                            end
                        end
                    end else if (last) begin
                        n_res.status = ST_NOTFOUND;
                        n_state      = S_DONE;
                    end
                end
            end
            S_SHIFT: begin
                if (r_pvld) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pidx - IW'(1);
                    if (last) begin
                        n_count = r_count - CW'(1);
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (r_pvld) begin
                    // strict less keeps ties at the entry nearest the head
                    if (r_pidx == '0 || alu.less) begin
                        n_best     = rd_entry;
                        n_best_idx = r_pidx;
                    end
                    if (last) begin
                        n_res   = '{ST_OK, n_best.task_id, n_best.static_prio,
                                    n_best.dynamic_prio};
                        n_idx   = '0;
                        n_pvld  = 1'b0;
                        n_state = S_AGE;
                    end
                end
            end
            S_AGE: begin
                if (r_pvld) begin
                    ram_we    = 1'b1;
                    ram_wdata = '{rd_entry.task_id, rd_entry.static_prio,
                                  (r_pidx == r_best_idx) ? rd_entry.static_prio
                                                         : alu.aged};
                    if (last) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_pvld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_pvld    <= n_pvld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_pidx     <= n_pidx;
        r_best_idx <= n_best_idx;
        r_best     <= n_best;
        r_req      <= n_req;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= AGING_STEP_RST;
            r_floor   <= PRIO_FLOOR_RST;
            r_ceiling <= PRIO_CEILING_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_AGING_STEP:   r_step    <= i_cfg_wdata[5:0];
                CFG_PRIO_FLOOR:   r_floor   <= i_cfg_wdata;
                CFG_PRIO_CEILING: r_ceiling <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- test/aps_result_checker.sv -----
// Checker for the aging priority scheduler: predicts each result and compares it.
`timescale 1ns / 1ps
module aps_result_checker import aps_pkg::*; #(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  t_in_item   i_in_item,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  t_out_item  i_out_item,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_addr,
    input  logic [7:0] i_cfg_wdata,
    output int         o_fail_count,
    output int         o_pending
);

    t_entry            ready_tbl [MAX_TASKS];
    int                ready_cnt = 0;
    logic signed [5:0] age_step  = AGING_STEP_RST;
    logic signed [7:0] floor_lim = PRIO_FLOOR_RST;
    logic signed [7:0] ceil_lim  = PRIO_CEILING_RST;
    t_out_item         awaited_results [$];
    t_out_item         want;
    int                mismatches = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic int sx8(logic [7:0] v);
        return int'($signed(v));
    endfunction

    // Applies one item to the shadow ready table and returns the result it gives.
    function automatic t_out_item run_table_op(t_in_item it);
        t_out_item res;
        int        hit;
        int        best;
        int        aged;
        res  = '0;
        hit  = -1;
        best = 0;
        case (it.opcode)
            OP_APPEND: begin
                if (ready_cnt >= MAX_TASKS) begin
                    res.status = ST_FULL;
                end else begin
                    ready_tbl[ready_cnt] = {it.task_id, it.static_prio, it.dynamic_prio};
                    ready_cnt++;
                    res = {ST_OK, it.task_id, it.static_prio, it.dynamic_prio};
                end
            end
            OP_REMOVE, OP_SETPRIO, OP_QUERY: begin
                if (ready_cnt == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    // duplicates: the entry nearest the head wins
                    for (int i = 0; i < ready_cnt; i++)
                        if (hit < 0 && ready_tbl[i].task_id == it.task_id)
                            hit = i;
                    if (hit < 0) begin
                        res.status = ST_NOTFOUND;
                    end else begin
                        if (it.opcode == OP_SETPRIO) begin
                            ready_tbl[hit].static_prio  = it.static_prio;
                            ready_tbl[hit].dynamic_prio = it.static_prio;
                        end
                        res = {ST_OK, ready_tbl[hit]};
                        if (it.opcode == OP_REMOVE) begin
                            for (int i = hit; i + 1 < ready_cnt; i++)
                                ready_tbl[i] = ready_tbl[i + 1];
                            ready_cnt--;
                        end
                    end
                end
            end
            OP_SCHED: begin
                if (ready_cnt == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    for (int i = 1; i < ready_cnt; i++)
                        if (sx8(ready_tbl[i].dynamic_prio) < sx8(ready_tbl[best].dynamic_prio))
                            best = i;
                    res = {ST_OK, ready_tbl[best]};
                    // floor first; inverted bounds: floor if below it, else ceiling
                    for (int i = 0; i < ready_cnt; i++) begin
                        aged = sx8(ready_tbl[i].dynamic_prio) + int'($signed(age_step));
                        if (aged < sx8(floor_lim))
                            aged = sx8(floor_lim);
                        else if (aged > sx8(ceil_lim))
                            aged = sx8(ceil_lim);
                        ready_tbl[i].dynamic_prio = aged[7:0];
                    end
                    ready_tbl[best].dynamic_prio = ready_tbl[best].static_prio;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ready_cnt = 0;
            age_step  = AGING_STEP_RST;
            floor_lim = PRIO_FLOOR_RST;
            ceil_lim  = PRIO_CEILING_RST;
            awaited_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_AGING_STEP:   age_step  = i_cfg_wdata[5:0];
                    CFG_PRIO_FLOOR:   floor_lim = i_cfg_wdata;
                    CFG_PRIO_CEILING: ceil_lim  = i_cfg_wdata;
                    default: ;
                endcase
            end
            // pop before push: a result never belongs to the item taken at the same edge
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: result with no item waiting: st=%0d id=%0d sp=%0d dp=%0d",
                                 $time, i_out_item.status, i_out_item.out_task_id,
                                 $signed(i_out_item.out_static_prio),
                                 $signed(i_out_item.out_dynamic_prio));
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    if (i_out_item.status !== want.status
                        || i_out_item.out_task_id !== want.out_task_id
                        || i_out_item.out_static_prio !== want.out_static_prio
                        || i_out_item.out_dynamic_prio !== want.out_dynamic_prio) begin
                        if (mismatches < 10)
                            $display({"%0t: mismatch exp st=%0d id=%0d sp=%0d dp=%0d",
                                      " got st=%0d id=%0d sp=%0d dp=%0d"},
                                     $time, want.status, want.out_task_id,
                                     $signed(want.out_static_prio),
                                     $signed(want.out_dynamic_prio),
                                     i_out_item.status, i_out_item.out_task_id,
                                     $signed(i_out_item.out_static_prio),
                                     $signed(i_out_item.out_dynamic_prio));
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                awaited_results.push_back(run_table_op(i_in_item));
        end
        o_fail_count <= mismatches;
        o_pending    <= awaited_results.size();
    end

endmodule

// ----- test/tb_aging_priority_scheduler.sv -----
// Testbench top for the aging priority scheduler: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module tb_aging_priority_scheduler;
    import aps_pkg::*;

    localparam int QUIET_LIMIT    = 4000;
    localparam int DRAIN_CYCLES   = 48;
    localparam int PHASES         = 10;
    localparam int ITEMS_PER_HALF = 31;

    // opcodes the block leaves unused
    localparam logic [2:0] OP_SPARE_A = 3'd5;
    localparam logic [2:0] OP_SPARE_B = 3'd6;
    localparam logic [2:0] OP_SPARE_C = 3'd7;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    t_in_item   in_item   = '0;
    logic       in_stall;
    logic       out_valid;
    t_out_item  out_item;
    logic       out_stall = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [1:0] cfg_addr  = CFG_AGING_STEP;
    logic [7:0] cfg_wdata = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles  = 0;
    int fail_count;
    int pending;

    int step_tab  [PHASES] = '{-1, 16, -16, 5, -3, 16, -7, 0, 0, 1};
    int floor_tab [PHASES] = '{-128, -128, -128, -20, -128, 127, 40, -128, 0, 127};
    int ceil_tab  [PHASES] = '{127, 127, 127, 30, -128, 127, -40, 127, 0, -128};

    always #10 clk = ~clk;

    aging_priority_scheduler dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata)
    );

    aps_result_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    function automatic t_in_item mk_item(logic [2:0] op, logic [7:0] id, int sp, int dp);
        return {op, id, sp[7:0], dp[7:0]};
    endfunction

    // mostly small values and extremes so ties and saturation come up often
    function automatic logic [7:0] pick_prio();
        int pick;
        int v;
        pick = $urandom_range(99);
        if (pick < 40)
            v = int'($urandom_range(8)) - 4;
        else if (pick < 48)
            v = -128;
        else if (pick < 55)
            v = 127;
        else
            v = $urandom_range(255);
        return v[7:0];
    endfunction

    // small id pool at both ends of the range so lookups hit
    function automatic logic [7:0] pick_id();
        logic [7:0] id;
        if ($urandom_range(9) == 0)
            return 8'($urandom_range(255));
        id = 8'($urandom_range(7));
        if ($urandom_range(1))
            id = id | 8'hF8;
        return id;
    endfunction

    function automatic t_in_item rand_item(bit filling);
        t_in_item it;
        int       pick;
        it.opcode       = OP_QUERY;
        it.task_id      = pick_id();
        it.static_prio  = pick_prio();
        it.dynamic_prio = pick_prio();
        pick = $urandom_range(99);
        if (pick < 4) begin
            it = $bits(t_in_item)'($urandom);
        end else if (pick < (filling ? 55 : 15)) begin
            it.opcode = OP_APPEND;
        end else begin
            pick = $urandom_range(99);
            if (pick < 30)
                it.opcode = OP_SCHED;
            else if (pick < (filling ? 45 : 70))
                it.opcode = OP_REMOVE;
            else if (pick < (filling ? 75 : 85))
                it.opcode = OP_QUERY;
            else
                it.opcode = OP_SETPRIO;
        end
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
    endtask

    // pending is registered in the checker, hence the first wait
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(input int stp, input int lo, input int hi);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_AGING_STEP;
        cfg_wdata <= stp[7:0];
        @(posedge clk);
        cfg_addr  <= CFG_PRIO_FLOOR;
        cfg_wdata <= lo[7:0];
        @(posedge clk);
        cfg_addr  <= CFG_PRIO_CEILING;
        cfg_wdata <= hi[7:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin : stimulus
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 29;
        recv_idle_pct = 72;

        // empty table, spare opcodes
        send_item(mk_item(OP_SCHED, 8'd0, 0, 0));
        send_item(mk_item(OP_REMOVE, 8'd5, 0, 0));
        send_item(mk_item(OP_SETPRIO, 8'd5, 1, 1));
        send_item(mk_item(OP_QUERY, 8'd5, 0, 0));
        send_item(mk_item(OP_SPARE_A, 8'hAA, 1, 2));
        send_item(mk_item(OP_SPARE_B, 8'h55, -128, 127));
        send_item(mk_item(OP_SPARE_C, 8'hFF, -1, -1));
        // extremes, a duplicate id and a tie on the lowest dynamic value
        send_item(mk_item(OP_APPEND, 8'd0, -128, 127));
        send_item(mk_item(OP_APPEND, 8'd255, 127, -128));
        send_item(mk_item(OP_APPEND, 8'd0, 3, 3));
        send_item(mk_item(OP_APPEND, 8'd9, 0, -128));
        send_item(mk_item(OP_QUERY, 8'd0, 0, 0));
        send_item(mk_item(OP_QUERY, 8'd77, 0, 0));
        send_item(mk_item(OP_REMOVE, 8'd77, 0, 0));
        send_item(mk_item(OP_SCHED, 8'd0, 0, 0));
        send_item(mk_item(OP_SCHED, 8'd0, 0, 0));
        send_item(mk_item(OP_SETPRIO, 8'd0, -128, 0));
        send_item(mk_item(OP_SETPRIO, 8'd9, 127, 0));
        send_item(mk_item(OP_SCHED, 8'd0, 0, 0));
        send_item(mk_item(OP_REMOVE, 8'd0, 0, 0));
        send_item(mk_item(OP_REMOVE, 8'd9, 0, 0));
        send_item(mk_item(OP_QUERY, 8'd0, 0, 0));
        send_item(mk_item(OP_SCHED, 8'd0, 0, 0));
        send_item(mk_item(OP_APPEND, 8'd200, 127, 127));

        for (int p = 0; p < PHASES; p++) begin
            if (p == 3) begin
                send_idle_pct = 72;
                recv_idle_pct = 29;
            end else if (p == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p > 0) begin
                settle();
                if (p == 8)
                    program_regs(int'($urandom_range(32)) - 16, $urandom_range(255),
                                 $urandom_range(255));
                else
                    program_regs(step_tab[p], floor_tab[p], ceil_tab[p]);
            end
            // first half fills the table, second half drains it
            for (int n = 0; n < 2 * ITEMS_PER_HALF; n++)
                send_item(rand_item(n < ITEMS_PER_HALF));
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/aps_pkg.sv
src/aps_ram.sv
src/aps_alu.sv
src/aging_priority_scheduler.sv
test/aps_result_checker.sv
test/tb_aging_priority_scheduler.sv
